>>> sv/unique_value_ordered_list_top_defines.svh
// Assertion helpers shared by the list block.
`ifndef UNIQUE_VALUE_ORDERED_LIST_TOP_DEFINES_SVH
`define UNIQUE_VALUE_ORDERED_LIST_TOP_DEFINES_SVH

// Check a consequence in the same cycle as its trigger.
`define UVOL_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check a consequence in the cycle after its trigger.
`define UVOL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/uvol_pkg.sv
package uvol_pkg;

  localparam int ValueW = 32;
  localparam int KindW  = 3;
  localparam int StatW  = 3;
  localparam int CountW = 5;

  // Operation codes
  localparam logic [KindW-1:0] K_INS_FRONT = 3'd0;
  localparam logic [KindW-1:0] K_INS_BACK  = 3'd1;
  localparam logic [KindW-1:0] K_REM_FRONT = 3'd2;
  localparam logic [KindW-1:0] K_REM_BACK  = 3'd3;
  localparam logic [KindW-1:0] K_REM_VALUE = 3'd4;
  localparam logic [KindW-1:0] K_SEARCH    = 3'd5;
  localparam logic [KindW-1:0] K_CLEAR     = 3'd6;

  // Status codes
  localparam logic [StatW-1:0] ST_OK       = 3'd0;
  localparam logic [StatW-1:0] ST_DUP      = 3'd1;
  localparam logic [StatW-1:0] ST_FULL     = 3'd2;
  localparam logic [StatW-1:0] ST_EMPTY    = 3'd3;
  localparam logic [StatW-1:0] ST_NOTFOUND = 3'd4;

endpackage

>>> sv/uvol_ifs.sv
interface uvol_req_if import uvol_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [KindW-1:0]         kind;
  logic signed [ValueW-1:0] value;

  modport source (output valid, kind, value, input ready);
  modport sink (input valid, kind, value, output ready);
endinterface

interface uvol_rsp_if import uvol_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [StatW-1:0]  status;
  logic              found;
  logic [CountW-1:0] count;

  modport source (output valid, status, found, count, input ready);
  modport sink (input valid, status, found, count, output ready);
endinterface

>>> sv/uvol_store.sv
module uvol_store import uvol_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [ValueW-1:0] wr_data,
  input  logic [AW-1:0]     rd_addr,
  output logic [ValueW-1:0] rd_data
);

  logic [ValueW-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> sv/uvol_ctrl.sv
`include "unique_value_ordered_list_top_defines.svh"

module uvol_ctrl import uvol_pkg::*; #(
  parameter int CAPACITY = 16,
  parameter int AW       = 4
) (
  input  logic              clk,
  input  logic              rst,
  uvol_req_if.sink          req,
  uvol_rsp_if.source        rsp,
  output logic              wr_en,
  output logic [AW-1:0]     wr_addr,
  output logic [ValueW-1:0] wr_data,
  output logic [AW-1:0]     rd_addr,
  input  logic [ValueW-1:0] rd_data
);

  localparam int LW = $clog2(CAPACITY + 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_SHIFT = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]        state;
  logic [KindW-1:0]  op;
  logic [ValueW-1:0] val;
  logic [AW-1:0]     head;
  logic [LW-1:0]     len;
  logic [LW-1:0]     idx;
  logic [LW-1:0]     wr_idx;
  logic              pend;
  logic [StatW-1:0]  res_status;
  logic              res_found;

  logic [AW-1:0]     head_dec;
  logic [AW-1:0]     head_inc;
  logic              match;
  logic              scan_end;
  logic              ins_ok;
  logic              is_insert;

  // Map a list position onto the circular store
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [LW-1:0] pos);
    logic [LW:0] sum;
    sum = (LW+1)'(h) + (LW+1)'(pos);
    if (sum >= (LW+1)'(CAPACITY)) begin
      sum = sum - (LW+1)'(CAPACITY);
    end
    return AW'(sum);
  endfunction

  assign head_dec  = (head == '0) ? AW'(CAPACITY - 1) : head - 1'b1;
  assign head_inc  = (head == AW'(CAPACITY - 1)) ? '0 : head + 1'b1;
  assign match     = pend && (rd_data == val);
  assign scan_end  = match || (idx >= len);
  assign is_insert = (op == K_INS_FRONT) || (op == K_INS_BACK);
  assign ins_ok    = is_insert && !match && (len < LW'(CAPACITY));
  assign req.ready = (state == S_IDLE);
  assign rd_addr   = phys(head, idx);

  // Drive the store write port: insert on scan end, gap closing while shifting
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = phys(head, wr_idx);
    wr_data = rd_data;
    if (state == S_SCAN && scan_end && ins_ok) begin
      wr_en   = 1'b1;
      wr_addr = (op == K_INS_FRONT) ? head_dec : phys(head, len);
      wr_data = val;
    end else if (state == S_SHIFT && pend) begin
      wr_en = 1'b1;
    end
  end

  // Sequence one transaction at a time
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      len       <= '0;
      pend      <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      // Drop the result once taken, unless a new one loads in the same cycle
      if (rsp.valid && rsp.ready && state != S_DONE) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            op        <= req.kind;
            val       <= req.value;
            idx       <= '0;
            pend      <= 1'b0;
            res_found <= 1'b0;
            case (req.kind)
              K_INS_FRONT, K_INS_BACK, K_REM_VALUE, K_SEARCH: begin
                res_status <= ST_OK;
                state      <= S_SCAN;
              end
              K_REM_FRONT: begin
                state <= S_DONE;
                if (len == '0) begin
                  res_status <= ST_EMPTY;
                end else begin
                  res_status <= ST_OK;
                  head       <= head_inc;
                  len        <= len - 1'b1;
                end
              end
              K_REM_BACK: begin
                state <= S_DONE;
                if (len == '0) begin
                  res_status <= ST_EMPTY;
                end else begin
                  res_status <= ST_OK;
                  len        <= len - 1'b1;
                end
              end
              K_CLEAR: begin
                res_status <= ST_OK;
                state      <= S_DONE;
                len        <= '0;
              end
              default: begin
                res_status <= ST_OK;
                state      <= S_DONE;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (scan_end) begin
            pend      <= 1'b0;
            res_found <= (op == K_SEARCH) && match;
            if (is_insert) begin
              state <= S_DONE;
              if (match) begin
                res_status <= ST_DUP;
              end else if (!ins_ok) begin
                res_status <= ST_FULL;
              end else begin
                len <= len + 1'b1;
                if (op == K_INS_FRONT) begin
                  head <= head_dec;
                end
              end
            end else if (op == K_REM_VALUE && match) begin
              // idx already points one past the match
              wr_idx <= idx - 1'b1;
              state  <= S_SHIFT;
            end else begin
              state <= S_DONE;
              if (op == K_REM_VALUE) begin
                res_status <= ST_NOTFOUND;
              end
            end
          end else begin
            idx  <= idx + 1'b1;
            pend <= 1'b1;
          end
        end
        S_SHIFT: begin
          if (pend) begin
            wr_idx <= wr_idx + 1'b1;
          end
          if (idx < len) begin
            idx  <= idx + 1'b1;
            pend <= 1'b1;
          end else begin
            pend <= 1'b0;
          end
          if (!pend && idx >= len) begin
            len   <= len - 1'b1;
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.valid  <= 1'b1;
            rsp.status <= res_status;
            rsp.found  <= res_found;
            rsp.count  <= CountW'(len);
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `UVOL_ASSERT_SAME(a_len_bound, 1'b1, len <= LW'(CAPACITY), "length above capacity")
  `UVOL_ASSERT_SAME(a_head_bound, 1'b1, head <= AW'(CAPACITY - 1), "head out of range")
  `UVOL_ASSERT_SAME(a_wr_state, wr_en, state == S_SCAN || state == S_SHIFT, "write outside walk")
  `UVOL_ASSERT_SAME(a_shift_order, state == S_SHIFT, wr_idx < idx, "gap write not behind read")
  `UVOL_ASSERT_NEXT(a_busy, req.valid && req.ready, !req.ready, "accepted while busy")

endmodule

>>> sv/unique_value_ordered_list_top.sv
// Path from acceptance to the result register: remove front/back, clear and unused kinds go
//   straight to the done state; insert, search and remove-by-value first scan the stored
//   entries (one stored entry compared per cycle); a remove-by-value hit then closes the gap.
// Throughput: one transaction at a time, accepted the cycle after the previous result loads;
//   a result still held by the sink delays the next load.
// Reset: synchronous; clears count, head pointer and handshake state, store left undefined.
module unique_value_ordered_list_top import uvol_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input logic        clk,
  input logic        rst,
  uvol_req_if.sink   req,
  uvol_rsp_if.source rsp
);

  localparam int AW = $clog2(CAPACITY);

  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [ValueW-1:0] wr_data;
  logic [AW-1:0]     rd_addr;
  logic [ValueW-1:0] rd_data;

  uvol_ctrl #(
    .CAPACITY(CAPACITY),
    .AW(AW)
  ) u_ctrl (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp),
    .wr_en(wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  uvol_store #(
    .DEPTH(CAPACITY),
    .AW(AW)
  ) u_store (
    .clk(clk),
    .wr_en(wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

endmodule

>>> bench/unique_value_ordered_list_top_tb.sv
module unique_value_ordered_list_top_tb;
  import uvol_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAPACITY = 16;
  localparam int RANDOM_ITEMS = 1500;
  localparam logic [KindW-1:0] K_UNUSED = 3'd7;

  typedef struct packed {
    logic [StatW-1:0]  status;
    logic              found;
    logic [CountW-1:0] count;
  } list_result_t;

  typedef struct {
    logic [KindW-1:0]  kind;
    logic [ValueW-1:0] value;
    int                reps;
    bit                fixed;
    list_result_t      outcome;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  uvol_req_if req_ch ();
  uvol_rsp_if rsp_ch ();

  unique_value_ordered_list_top #(
    .CAPACITY(CAPACITY)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  // Shadow copy of the stored sequence, front at index 0
  logic [ValueW-1:0] shadow_list[$];
  list_result_t      pending_results[$];
  stim_row_t         directed_rows[$];
  logic [ValueW-1:0] value_pool[32];
  int                error_count = 0;
  int                burst_left = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Position of the first stored match, or the list size when absent
  function automatic int locate_value(logic [ValueW-1:0] v);
    for (int i = 0; i < shadow_list.size(); i++) begin
      if (shadow_list[i] == v) return i;
    end
    return shadow_list.size();
  endfunction

  // Apply one operation to the shadow list and return its result
  function automatic list_result_t apply_list_op(logic [KindW-1:0] kind,
                                                 logic [ValueW-1:0] v);
    list_result_t res;
    int pos;
    res = '0;
    res.status = ST_OK;
    pos = locate_value(v);
    case (kind)
      K_INS_FRONT, K_INS_BACK: begin
        if (pos < shadow_list.size()) res.status = ST_DUP;
        else if (shadow_list.size() >= CAPACITY) res.status = ST_FULL;
        else if (kind == K_INS_FRONT) shadow_list.push_front(v);
        else shadow_list.push_back(v);
      end
      K_REM_FRONT: begin
        if (shadow_list.size() == 0) res.status = ST_EMPTY;
        else void'(shadow_list.pop_front());
      end
      K_REM_BACK: begin
        if (shadow_list.size() == 0) res.status = ST_EMPTY;
        else void'(shadow_list.pop_back());
      end
      K_REM_VALUE: begin
        if (pos >= shadow_list.size()) res.status = ST_NOTFOUND;
        else shadow_list.delete(pos);
      end
      K_SEARCH: res.found = (pos < shadow_list.size());
      K_CLEAR: shadow_list.delete();
      default: ;
    endcase
    res.count = CountW'(shadow_list.size());
    return res;
  endfunction

  function automatic void add_row(logic [KindW-1:0] kind, logic [ValueW-1:0] v, int reps,
                                  bit fixed, logic [StatW-1:0] status, logic found,
                                  logic [CountW-1:0] count);
    stim_row_t row;
    row.kind = kind;
    row.value = v;
    row.reps = reps;
    row.fixed = fixed;
    row.outcome.status = status;
    row.outcome.found = found;
    row.outcome.count = count;
    directed_rows.push_back(row);
  endfunction

  // Mostly short gaps, a few long ones, and bursts with none
  function automatic int pick_gap();
    int r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      burst_left = $urandom_range(20, 60);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
    error_count++;
  endtask

  // Drive one transaction, hold it until accepted, then queue its expected result
  task automatic send_op(logic [KindW-1:0] kind, logic [ValueW-1:0] v, bit fixed,
                         list_result_t outcome);
    int gap;
    list_result_t predicted;
    gap = pick_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.kind  <= kind;
    req_ch.value <= v;
    do @(posedge clk); while (!req_ch.ready);
    predicted = apply_list_op(kind, v);
    pending_results.push_back(fixed ? outcome : predicted);
  endtask

  // Response ready: runs of ready, short and long stalls, and long clean stretches
  initial begin
    int r;
    int run;
    bit level;
    rsp_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        level = 1'b1;
        run = $urandom_range(1, 8);
      end else if (r < 85) begin
        level = 1'b0;
        run = $urandom_range(1, 3);
      end else if (r < 95) begin
        level = 1'b0;
        run = $urandom_range(10, 40);
      end else begin
        level = 1'b1;
        run = $urandom_range(100, 300);
      end
      repeat (run) begin
        rsp_ch.ready <= level;
        @(posedge clk);
      end
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    list_result_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_results.size() == 0) begin
        $display("[%0t] result with no transaction outstanding", $realtime);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (rsp_ch.status !== want.status)
          report_mismatch("status", int'(rsp_ch.status), int'(want.status));
        if (rsp_ch.found !== want.found)
          report_mismatch("found", int'(rsp_ch.found), int'(want.found));
        if (rsp_ch.count !== want.count)
          report_mismatch("count", int'(rsp_ch.count), int'(want.count));
      end
    end
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    stim_row_t row;
    int r;
    int phase_left;
    bit growing;
    logic [KindW-1:0] kind;
    logic [ValueW-1:0] v;
    list_result_t none;

    none = '0;
    req_ch.valid <= 1'b0;
    req_ch.kind  <= K_INS_FRONT;
    req_ch.value <= '0;

    // Empty list first, then extremes, duplicate, full, gap closing and clear
    add_row(K_REM_FRONT, 32'h0, 1, 1, ST_EMPTY, 1'b0, 5'd0);
    add_row(K_REM_BACK, 32'h0, 1, 1, ST_EMPTY, 1'b0, 5'd0);
    add_row(K_REM_VALUE, 32'h0, 1, 1, ST_NOTFOUND, 1'b0, 5'd0);
    add_row(K_SEARCH, 32'h0, 1, 1, ST_OK, 1'b0, 5'd0);
    add_row(K_CLEAR, 32'h0, 1, 1, ST_OK, 1'b0, 5'd0);
    add_row(K_UNUSED, 32'hffffffff, 1, 1, ST_OK, 1'b0, 5'd0);
    add_row(K_INS_FRONT, 32'h80000000, 1, 1, ST_OK, 1'b0, 5'd1);
    add_row(K_INS_BACK, 32'h7fffffff, 1, 1, ST_OK, 1'b0, 5'd2);
    add_row(K_INS_FRONT, 32'h7fffffff, 1, 1, ST_DUP, 1'b0, 5'd2);
    add_row(K_SEARCH, 32'h80000000, 1, 1, ST_OK, 1'b1, 5'd2);
    add_row(K_SEARCH, 32'h0, 1, 1, ST_OK, 1'b0, 5'd2);
    add_row(K_REM_VALUE, 32'h0, 1, 1, ST_NOTFOUND, 1'b0, 5'd2);
    add_row(K_INS_BACK, 32'h0, 1, 0, ST_OK, 1'b0, 5'd0);
    add_row(K_INS_FRONT, 32'hffffffff, 1, 0, ST_OK, 1'b0, 5'd0);
    add_row(K_INS_BACK, 32'h55555555, 12, 0, ST_OK, 1'b0, 5'd0);
    add_row(K_INS_BACK, 32'h0aaaaaaa, 1, 1, ST_FULL, 1'b0, 5'd16);
    add_row(K_INS_FRONT, 32'h12345678, 1, 1, ST_FULL, 1'b0, 5'd16);
    add_row(K_INS_FRONT, 32'h0, 1, 1, ST_DUP, 1'b0, 5'd16);
    add_row(K_UNUSED, 32'h0, 1, 1, ST_OK, 1'b0, 5'd16);
    add_row(K_SEARCH, 32'h5555555a, 1, 1, ST_OK, 1'b1, 5'd16);
    add_row(K_REM_VALUE, 32'h5555555a, 1, 1, ST_OK, 1'b0, 5'd15);
    add_row(K_REM_VALUE, 32'h80000000, 1, 0, ST_OK, 1'b0, 5'd0);
    add_row(K_REM_VALUE, 32'h55555560, 1, 0, ST_OK, 1'b0, 5'd0);
    add_row(K_REM_FRONT, 32'h0, 1, 0, ST_OK, 1'b0, 5'd0);
    add_row(K_REM_BACK, 32'h0, 1, 0, ST_OK, 1'b0, 5'd0);
    add_row(K_CLEAR, 32'h0, 1, 1, ST_OK, 1'b0, 5'd0);

    // Small pool so that duplicates and hits are common
    for (int i = 0; i < 32; i++) value_pool[i] = $urandom;
    value_pool[0] = 32'h80000000;
    value_pool[1] = 32'h7fffffff;
    value_pool[2] = 32'h0;
    value_pool[3] = 32'hffffffff;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Walk the directed table
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      for (int k = 0; k < row.reps; k++) begin
        send_op(row.kind, row.value + k, row.fixed, row.outcome);
      end
    end

    // Random part: alternate growing and shrinking phases
    growing = 1'b1;
    phase_left = $urandom_range(60, 200);
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (phase_left == 0) begin
        growing = !growing;
        phase_left = $urandom_range(60, 200);
      end
      phase_left--;

      r = $urandom_range(0, 99);
      if (growing) begin
        if (r < 30) kind = K_INS_BACK;
        else if (r < 55) kind = K_INS_FRONT;
        else if (r < 62) kind = K_REM_FRONT;
        else if (r < 68) kind = K_REM_BACK;
        else if (r < 81) kind = K_REM_VALUE;
        else if (r < 97) kind = K_SEARCH;
        else if (r < 98) kind = K_CLEAR;
        else kind = K_UNUSED;
      end else begin
        if (r < 12) kind = K_INS_BACK;
        else if (r < 24) kind = K_INS_FRONT;
        else if (r < 40) kind = K_REM_FRONT;
        else if (r < 55) kind = K_REM_BACK;
        else if (r < 80) kind = K_REM_VALUE;
        else if (r < 95) kind = K_SEARCH;
        else if (r < 98) kind = K_CLEAR;
        else kind = K_UNUSED;
      end

      r = $urandom_range(0, 99);
      if (r < 25 && shadow_list.size() > 0) v = shadow_list[$urandom_range(0, shadow_list.size() - 1)];
      else if (r < 85) v = value_pool[$urandom_range(0, 31)];
      else v = $urandom;

      send_op(kind, v, 1'b0, none);
    end
    req_ch.valid <= 1'b0;

    // Drain, then allow for the longest walk through the store
    while (pending_results.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
